// ===== src/cobsrx_pkg.sv =====
// Shared types, constants and the byte-wide CRC-32 step for the COBS frame receiver.
// No dependencies; compiled first.
package cobsrx_pkg;

    localparam logic        ACT_FEED    = 1'b0;
    localparam logic        ACT_READ    = 1'b1;

    localparam int unsigned HDR_BYTES   = 20;
    localparam int unsigned CRC_BYTES   = 4;
    localparam int unsigned HDR_KEEP    = 12;
    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_RESIDUE = 32'hDEBB_20E3;

    localparam int unsigned TDATA_IN_W  = 24;
    localparam int unsigned TDATA_OUT_W = 96;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_ACCEPT = 2'd1,
        EV_REJECT = 2'd2
    } event_t;

    typedef struct packed {
        logic [31:0] rejected_count;
        logic [7:0]  read_data;
        logic [31:0] sequence_number;
        logic [7:0]  message_type;
        logic [10:0] message_length;
        event_t      event_res;
    } result_t;

    // Reflected CRC-32 advanced over one byte, LSB first.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== src/cobsrx_skid.sv =====
// Two-entry output buffer: a registered output stage plus one skid entry.
// Breaks the ready path between the result stage and the downstream sink. No package use.
module cobsrx_skid #(
    parameter int unsigned WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [WIDTH-1:0] in_data,
    output logic             in_ready,
    output logic             out_valid,
    output logic [WIDTH-1:0] out_data,
    input  logic             out_ready
);

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [WIDTH-1:0] out_data_reg;
    logic [WIDTH-1:0] out_data_next;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    logic [WIDTH-1:0] skid_data_reg;
    logic [WIDTH-1:0] skid_data_next;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready)
        begin
            // Output slot frees up: drain the skid entry first, else pass input through.
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_valid;
                out_data_next  = in_data;
            end
        end
        else if (in_valid && !skid_valid_reg)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// ===== src/cobsrx_core.sv =====
// COBS decoder, running CRC-32, decoded-byte memory and frame judgement.
// One registered transaction per cycle while res_ready keeps up. Depends on cobsrx_pkg.
module cobsrx_core #(
    parameter int unsigned ENCODED_BYTES = 1024,
    parameter int unsigned DECODED_BYTES = 1024
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    in_action,
    input  logic [7:0]              in_byte,
    input  logic [9:0]              in_index,
    input  logic [15:0]             protocol_version,
    output logic                    res_valid,
    output cobsrx_pkg::result_t     res,
    input  logic                    res_ready
);

    import cobsrx_pkg::*;

    localparam int unsigned ENC_W = $clog2(ENCODED_BYTES + 1);
    localparam int unsigned DEC_W = $clog2(DECODED_BYTES + 1);
    localparam int unsigned AW    = $clog2(DECODED_BYTES);

    logic             fire;
    logic             feed_nz;
    logic             delim;

    logic [ENC_W-1:0] enc_count_reg,  enc_count_next;
    logic             overflow_reg,   overflow_next;
    logic [7:0]       block_left_reg, block_left_next;
    logic             prev_ff_reg,    prev_ff_next;
    logic [DEC_W-1:0] dec_count_reg,  dec_count_next;
    logic             dec_error_reg,  dec_error_next;
    logic [31:0]      crc_reg,        crc_next;
    logic [7:0]       hdr_reg [HDR_KEEP];
    logic [7:0]       hdr_next [HDR_KEEP];

    logic [10:0]      acc_len_reg,    acc_len_next;
    logic [7:0]       acc_type_reg,   acc_type_next;
    logic [31:0]      acc_seq_reg,    acc_seq_next;
    logic [31:0]      reject_reg,     reject_next;
    event_t           event_reg,      event_next;
    logic             r_valid_reg,    r_valid_next;
    logic             rd_zero_reg,    rd_zero_next;

    logic             emit_en;
    logic [7:0]       emit_byte;
    logic             mem_we;
    logic [7:0]       mem [DECODED_BYTES];
    logic [7:0]       mem_q_reg;
    logic [31:0]      idx_ext;
    logic [AW-1:0]    raddr;
    logic [AW-1:0]    waddr;
    logic             rd_in_range;

    logic [15:0]      hdr_version;
    logic [31:0]      hdr_length;
    logic [31:0]      dec_ext;
    logic             frame_good;

    assign in_ready = !r_valid_reg || res_ready;
    assign fire     = in_valid && in_ready;
    assign feed_nz  = (in_action == ACT_FEED) && (in_byte != 8'd0);
    assign delim    = (in_action == ACT_FEED) && (in_byte == 8'd0) && (enc_count_reg != '0);

    assign idx_ext     = 32'(in_index);
    assign raddr       = idx_ext[AW-1:0];
    assign rd_in_range = idx_ext < 32'(DECODED_BYTES);
    assign waddr       = dec_count_reg[AW-1:0];

    assign hdr_version = {hdr_reg[1], hdr_reg[0]};
    assign hdr_length  = {hdr_reg[7], hdr_reg[6], hdr_reg[5], hdr_reg[4]};
    assign dec_ext     = 32'(dec_count_reg);
    assign frame_good  = !overflow_reg && !dec_error_reg && (block_left_reg == 8'd0)
                         && (dec_ext >= 32'(HDR_BYTES + CRC_BYTES))
                         && (crc_reg == CRC_RESIDUE)
                         && (hdr_version == protocol_version)
                         && (hdr_length == dec_ext - 32'(HDR_BYTES + CRC_BYTES));

    // COBS block tracking: decide which byte, if any, goes to the store.
    always_comb
    begin
        enc_count_next  = enc_count_reg;
        overflow_next   = overflow_reg;
        block_left_next = block_left_reg;
        prev_ff_next    = prev_ff_reg;
        emit_en         = 1'b0;
        emit_byte       = 8'd0;
        if (fire && feed_nz)
        begin
            if (enc_count_reg < ENC_W'(ENCODED_BYTES))
            begin
                enc_count_next = enc_count_reg + 1'b1;
                if (block_left_reg == 8'd0)
                begin
                    // Code byte: implied zero unless first block or after a full block.
                    emit_en         = (enc_count_reg != '0) && !prev_ff_reg;
                    block_left_next = in_byte - 8'd1;
                    prev_ff_next    = (in_byte == 8'hFF);
                end
                else
                begin
                    emit_en         = 1'b1;
                    emit_byte       = in_byte;
                    block_left_next = block_left_reg - 8'd1;
                end
            end
            else
            begin
                overflow_next = 1'b1;
            end
        end
    end

    // Store write, CRC update, header capture, and frame judgement.
    always_comb
    begin
        dec_count_next = dec_count_reg;
        dec_error_next = dec_error_reg;
        crc_next       = crc_reg;
        hdr_next       = hdr_reg;
        mem_we         = 1'b0;
        acc_len_next   = acc_len_reg;
        acc_type_next  = acc_type_reg;
        acc_seq_next   = acc_seq_reg;
        reject_next    = reject_reg;
        event_next     = event_reg;
        rd_zero_next   = rd_zero_reg;
        r_valid_next   = r_valid_reg && !res_ready;

        if (emit_en)
        begin
            if (dec_count_reg >= DEC_W'(DECODED_BYTES))
            begin
                dec_error_next = 1'b1;
            end
            else
            begin
                mem_we         = 1'b1;
                dec_count_next = dec_count_reg + 1'b1;
                crc_next       = crc32_byte(crc_reg, emit_byte);
                if (dec_count_reg < DEC_W'(HDR_KEEP))
                begin
                    hdr_next[dec_count_reg[3:0]] = emit_byte;
                end
            end
        end

        if (fire)
        begin
            r_valid_next = 1'b1;
            event_next   = EV_NONE;
            rd_zero_next = !((in_action == ACT_READ) && rd_in_range);
            if (delim)
            begin
                if (frame_good)
                begin
                    acc_len_next  = 11'(dec_count_reg - DEC_W'(CRC_BYTES));
                    acc_type_next = hdr_reg[2];
                    acc_seq_next  = {hdr_reg[11], hdr_reg[10], hdr_reg[9], hdr_reg[8]};
                    event_next    = EV_ACCEPT;
                end
                else
                begin
                    reject_next = reject_reg + 32'd1;
                    event_next  = EV_REJECT;
                end
                dec_count_next = '0;
                dec_error_next = 1'b0;
                crc_next       = CRC_INIT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enc_count_reg  <= '0;
            overflow_reg   <= 1'b0;
            block_left_reg <= 8'd0;
            prev_ff_reg    <= 1'b0;
            dec_count_reg  <= '0;
            dec_error_reg  <= 1'b0;
            crc_reg        <= CRC_INIT;
            acc_len_reg    <= 11'd0;
            acc_type_reg   <= 8'd0;
            acc_seq_reg    <= 32'd0;
            reject_reg     <= 32'd0;
            event_reg      <= EV_NONE;
            r_valid_reg    <= 1'b0;
            rd_zero_reg    <= 1'b1;
        end
        else
        begin
            // Delimiter clears the per-frame decoder state.
            if (fire && delim)
            begin
                enc_count_reg  <= '0;
                overflow_reg   <= 1'b0;
                block_left_reg <= 8'd0;
                prev_ff_reg    <= 1'b0;
            end
            else
            begin
                enc_count_reg  <= enc_count_next;
                overflow_reg   <= overflow_next;
                block_left_reg <= block_left_next;
                prev_ff_reg    <= prev_ff_next;
            end
            dec_count_reg <= dec_count_next;
            dec_error_reg <= dec_error_next;
            crc_reg       <= crc_next;
            acc_len_reg   <= acc_len_next;
            acc_type_reg  <= acc_type_next;
            acc_seq_reg   <= acc_seq_next;
            reject_reg    <= reject_next;
            event_reg     <= event_next;
            r_valid_reg   <= r_valid_next;
            rd_zero_reg   <= rd_zero_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hdr_reg <= hdr_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= emit_byte;
        end
        if (fire && (in_action == ACT_READ))
        begin
            mem_q_reg <= mem[raddr];
        end
    end

    assign res_valid           = r_valid_reg;
    assign res.event_res       = event_reg;
    assign res.message_length  = acc_len_reg;
    assign res.message_type    = acc_type_reg;
    assign res.sequence_number = acc_seq_reg;
    assign res.read_data       = rd_zero_reg ? 8'd0 : mem_q_reg;
    assign res.rejected_count  = reject_reg;

endmodule

// ===== src/cobs_crc32_frame_receiver.sv =====
// Top level of the COBS frame receiver: configuration register, stream packing,
// decoder core and output buffer. Depends on cobsrx_pkg, cobsrx_core, cobsrx_skid.
//
// Link bytes and read requests arrive as slave-side stream transactions, one per
// cycle; the block takes a transaction in every cycle in which the output side keeps
// up, and every transaction yields exactly one master-side transaction. A result
// is registered first in the decode and result register and then in the output
// register before it shows on m_tvalid. Zero bytes delimit frames; the
// nonzero bytes of a frame are COBS-decoded on the fly into a DECODED_BYTES memory
// while a reflected CRC-32 runs over each decoded byte. At a delimiter the frame is
// accepted when it decoded cleanly, holds at least 24 bytes, ends in its own CRC-32
// (little-endian), carries protocol_version in its header and a header length equal
// to decoded size minus 24; otherwise the wrapping reject counter advances. An empty
// frame yields no event. A read transaction (s_tuser high) returns the decoded byte
// at read_index; entries not written since reset read as don't-care. Every frame,
// accepted or not, overwrites the memory from position zero. Write protocol_version
// only while no transaction is in flight.
module cobs_crc32_frame_receiver #(
    parameter int unsigned ENCODED_BYTES = 1024,
    parameter int unsigned DECODED_BYTES = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [15:0]                          cfg_wdata,     // protocol_version
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [cobsrx_pkg::TDATA_IN_W-1:0]    s_tdata,       // link_byte[7:0], read_index[17:8]
    input  logic                                 s_tuser,       // action
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [cobsrx_pkg::TDATA_OUT_W-1:0]   m_tdata        // event_res[1:0],
                                                                // message_length[12:2],
                                                                // message_type[20:13],
                                                                // sequence_number[52:21],
                                                                // read_data[60:53],
                                                                // rejected_count[92:61]
);

    import cobsrx_pkg::*;

    localparam int unsigned RES_W = $bits(result_t);

    logic [15:0]            protocol_version_reg;
    result_t                core_res;
    logic                   core_res_valid;
    logic                   skid_in_ready;
    logic [RES_W-1:0]       skid_out_data;

    // Protocol version register; hold between writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            protocol_version_reg <= 16'd1;
        end
        else if (cfg_we)
        begin
            protocol_version_reg <= cfg_wdata;
        end
    end

    cobsrx_core #(
        .ENCODED_BYTES (ENCODED_BYTES),
        .DECODED_BYTES (DECODED_BYTES)
    ) u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .in_action        (s_tuser),
        .in_byte          (s_tdata[7:0]),
        .in_index         (s_tdata[17:8]),
        .protocol_version (protocol_version_reg),
        .res_valid        (core_res_valid),
        .res              (core_res),
        .res_ready        (skid_in_ready)
    );

    // Output buffer: decouple m_tready from s_tready.
    cobsrx_skid #(
        .WIDTH (RES_W)
    ) u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (core_res_valid),
        .in_data   (core_res),
        .in_ready  (skid_in_ready),
        .out_valid (m_tvalid),
        .out_data  (skid_out_data),
        .out_ready (m_tready)
    );

    // Result struct is already packed lowest field first; pad to whole bytes.
    assign m_tdata = {(TDATA_OUT_W - RES_W)'(0), skid_out_data};

`ifndef SYNTHESIS
    // Input side stalls only while a finished result waits downstream.
    a_stall_has_output: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no output pending");

    // Reject counter only ever advances by one.
    a_reject_step: assert property (@(posedge clk) disable iff (!rst_n)
        (core_res.rejected_count != $past(core_res.rejected_count))
        |-> (core_res.rejected_count == $past(core_res.rejected_count) + 32'd1))
        else $error("reject counter jumped");

    // An accepted frame always carries at least a full header.
    a_accept_length: assert property (@(posedge clk) disable iff (!rst_n)
        (core_res_valid && (core_res.event_res == EV_ACCEPT))
        |-> (core_res.message_length >= 11'(HDR_BYTES)))
        else $error("accepted frame shorter than header");
`endif

endmodule

// ===== tb/sv/cobsrx_result_checker.sv =====
// Result checker for the COBS frame receiver: watches the configuration port and
// both stream channels, predicts every result and compares it field by field.
// Depends on cobsrx_pkg.
module cobsrx_result_checker #(
    parameter int unsigned ENCODED_BYTES = 1024,
    parameter int unsigned DECODED_BYTES = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [15:0]                        cfg_wdata,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [cobsrx_pkg::TDATA_IN_W-1:0]  s_tdata,
    input  logic                               s_tuser,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [cobsrx_pkg::TDATA_OUT_W-1:0] m_tdata,
    input  logic                               drain_check,
    output int                                 failures,
    output int                                 pending,
    output int                                 written_hi
);
    timeunit 1ns;
    timeprecision 1ps;

    import cobsrx_pkg::*;

    logic [15:0]  version_reg;
    logic [10:0]  link_count;
    logic         overflowed;
    logic [7:0]   store [DECODED_BYTES];
    logic [10:0]  last_len;
    logic [7:0]   last_type;
    logic [31:0]  accepted_seq;
    logic [31:0]  reject_total;
    logic [31:0]  crc_acc;
    logic [7:0]   block_left;
    int unsigned  out_count;
    logic         bad_decode;
    logic         after_ff;
    int unsigned  store_high;
    result_t      expected_results[$];
    int           mismatches = 0;
    bit           drained = 1'b0;

    assign failures = mismatches;

    task automatic report(input string what, input logic [31:0] seen, input logic [31:0] wanted);
        // keep the log short when the design is badly broken
        if (mismatches < 50)
            $display("[%0t] mismatch: %s got 0x%0h expected 0x%0h", $time, what, seen, wanted);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] seen,
                               input logic [31:0] wanted);
        if (seen !== wanted)
            report(name, seen, wanted);
    endtask

    function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
        for (int k = 0; k < 8; k++)
            c = (c >> 1) ^ ((c[0] ^ b[k]) ? CRC_POLY : 32'd0);
        return c;
    endfunction

    function automatic void start_frame();
        link_count = '0;
        overflowed = 1'b0;
        crc_acc    = CRC_INIT;
        block_left = '0;
        out_count  = 0;
        bad_decode = 1'b0;
        after_ff   = 1'b0;
    endfunction

    function automatic void put_decoded(logic [7:0] b);
        if (out_count >= DECODED_BYTES)
            bad_decode = 1'b1;
        else
        begin
            store[out_count] = b;
            out_count++;
            if (out_count > store_high)
                store_high = out_count;
            crc_acc = crc_step(crc_acc, b);
        end
    endfunction

    function automatic bit frame_ok();
        if (overflowed || bad_decode || block_left != 0)
            return 1'b0;
        if (out_count < HDR_BYTES + CRC_BYTES)
            return 1'b0;
        if (crc_acc != CRC_RESIDUE)
            return 1'b0;
        if ({store[1], store[0]} != version_reg)
            return 1'b0;
        return {store[7], store[6], store[5], store[4]} == 32'(out_count - HDR_BYTES - CRC_BYTES);
    endfunction

    // Advance the receiver by one input transaction and return its result.
    function automatic result_t decode_link_item(logic act, logic [7:0] lb, logic [9:0] ri);
        result_t r;
        r.event_res = EV_NONE;
        r.read_data = 8'd0;
        if (act == ACT_READ)
        begin
            if (ri < DECODED_BYTES)
                r.read_data = store[ri];
        end
        else if (lb != 8'd0)
        begin
            if (link_count < ENCODED_BYTES)
            begin
                if (block_left == 0)
                begin
                    // a new code byte closes the previous block with a zero,
                    // except after a full 254-byte block
                    if (link_count != 0 && !after_ff)
                        put_decoded(8'd0);
                    block_left = lb - 8'd1;
                    after_ff   = (lb == 8'hFF);
                end
                else
                begin
                    put_decoded(lb);
                    block_left--;
                end
                link_count++;
            end
            else
                overflowed = 1'b1;
        end
        else if (link_count != 0)
        begin
            if (frame_ok())
            begin
                last_len     = 11'(out_count - CRC_BYTES);
                last_type    = store[2];
                accepted_seq = {store[11], store[10], store[9], store[8]};
                r.event_res  = EV_ACCEPT;
            end
            else
            begin
                reject_total++;
                r.event_res = EV_REJECT;
            end
            start_frame();
        end
        r.message_length  = last_len;
        r.message_type    = last_type;
        r.sequence_number = accepted_seq;
        r.rejected_count  = reject_total;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            version_reg  = 16'd1;
            last_len     = '0;
            last_type    = '0;
            accepted_seq = '0;
            reject_total = '0;
            store_high   = 0;
            start_frame();
            expected_results.delete();
        end
        else
        begin
            if (cfg_we)
                version_reg = cfg_wdata;
            if (s_tvalid && s_tready)
                expected_results.push_back(decode_link_item(s_tuser, s_tdata[7:0], s_tdata[17:8]));
            if (m_tvalid && m_tready)
            begin
                got = result_t'(m_tdata[$bits(result_t)-1:0]);
                if (expected_results.size() == 0)
                    report("result with nothing outstanding, event", 32'(got.event_res), 32'd0);
                else
                begin
                    want = expected_results.pop_front();
                    check_field("event_res", 32'(got.event_res), 32'(want.event_res));
                    check_field("message_length", 32'(got.message_length),
                                32'(want.message_length));
                    check_field("message_type", 32'(got.message_type), 32'(want.message_type));
                    check_field("sequence_number", got.sequence_number, want.sequence_number);
                    check_field("read_data", 32'(got.read_data), 32'(want.read_data));
                    check_field("rejected_count", got.rejected_count, want.rejected_count);
                end
            end
            if (drain_check && !drained)
            begin
                drained = 1'b1;
                while (expected_results.size() != 0)
                begin
                    want = expected_results.pop_front();
                    report("result never arrived, event", 32'd0, 32'(want.event_res));
                end
            end
        end
        pending    <= expected_results.size();
        written_hi <= store_high;
    end

endmodule

// ===== tb/sv/tb_cobs_crc32_frame_receiver.sv =====
// Top of the COBS frame receiver testbench: clock, reset, stimulus and verdict.
// Depends on cobsrx_pkg, cobs_crc32_frame_receiver and cobsrx_result_checker.
module tb_cobs_crc32_frame_receiver;
    timeunit 1ns;
    timeprecision 1ps;

    import cobsrx_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 60;

    // Ways to spoil an otherwise well-formed message.
    typedef enum int {
        FLAW_NONE,
        FLAW_VERSION,
        FLAW_LENGTH,
        FLAW_CRC,
        FLAW_SHORT,
        FLAW_CUT,
        FLAW_CODE
    } flaw_t;

    // Payload content styles.
    typedef enum int {
        PAY_MIXED,      // random bytes, zeros frequent
        PAY_NONZERO,    // no zeros, forces full 0xFF blocks
        PAY_SPACED      // a zero every 200 bytes, keeps encoding at size + 1
    } payload_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [15:0]            cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic                   drain_check;
    int                     failures;
    int                     pending;
    int                     written_hi;

    int          gap_pct = 0;
    int          stall_pct = 0;
    int          stall_left = 0;
    int          idle_cycles = 0;
    bit          quiet = 1'b0;
    logic [15:0] cur_version = 16'd1;
    int          items_sent = 0;
    int          frames_sent = 0;
    int          reads_sent = 0;
    int          versions_used = 1;

    logic [7:0]  raw_bytes[$];
    logic [7:0]  link_bytes[$];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    cobs_crc32_frame_receiver u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    cobsrx_result_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .drain_check (drain_check),
        .failures    (failures),
        .pending     (pending),
        .written_hi  (written_hi)
    );

    // Output side: hold m_tready low in bursts, at a rate set by stall_pct.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (!quiet && $urandom_range(99) < stall_pct)
        begin
            stall_left <= $urandom_range(6);
            m_tready   <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Watchdog: any transaction on either channel restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Present one input transaction, with an optional gap first, and hold it until taken.
    task automatic send_item(input logic act, input logic [7:0] lb, input logic [9:0] ri);
        if (!quiet && $urandom_range(99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {6'd0, ri, lb};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic feed(input logic [7:0] lb);
        send_item(ACT_FEED, lb, 10'($urandom));
    endtask

    // Read only entries written since reset; favor both ends of the written range.
    task automatic read_burst(input int n);
        logic [9:0] idx;
        repeat (n)
        begin
            if (written_hi > 0)
            begin
                case ($urandom_range(3))
                    0:       idx = 10'd0;
                    1:       idx = 10'(written_hi - 1);
                    default: idx = 10'($urandom_range(0, written_hi - 1));
                endcase
                send_item(ACT_READ, 8'($urandom), idx);
                reads_sent++;
            end
        end
    endtask

    function automatic void push_le(input logic [63:0] v, input int n);
        for (int i = 0; i < n; i++)
            raw_bytes.push_back(v[8*i +: 8]);
    endfunction

    function automatic logic [31:0] message_crc();
        logic [31:0] c;
        c = CRC_INIT;
        foreach (raw_bytes[i])
            for (int k = 0; k < 8; k++)
                c = (c >> 1) ^ ((c[0] ^ raw_bytes[i][k]) ? CRC_POLY : 32'd0);
        return ~c;
    endfunction

    // Standard COBS: each code byte counts the data bytes that follow it plus one.
    function automatic void cobs_encode();
        int         code_at;
        logic [7:0] code;
        link_bytes.delete();
        code_at = 0;
        link_bytes.push_back(8'd0);
        code = 8'd1;
        foreach (raw_bytes[i])
        begin
            if (raw_bytes[i] != 8'd0)
            begin
                link_bytes.push_back(raw_bytes[i]);
                code++;
            end
            if (raw_bytes[i] == 8'd0 || code == 8'hFF)
            begin
                link_bytes[code_at] = code;
                code_at = link_bytes.size();
                link_bytes.push_back(8'd0);
                code = 8'd1;
            end
        end
        link_bytes[code_at] = code;
    endfunction

    // Build a message (header, payload, CRC), spoil it as asked, encode and send it.
    task automatic send_message(input int pay_len, input flaw_t flaw, input payload_t kind);
        logic [15:0] ver;
        logic [31:0] len;
        logic [31:0] seq;
        logic [31:0] crc;
        raw_bytes.delete();
        if (flaw == FLAW_SHORT)
            repeat ($urandom_range(1, 23))
                raw_bytes.push_back(8'($urandom));
        else
        begin
            ver = cur_version;
            if (flaw == FLAW_VERSION)
                ver ^= 16'($urandom_range(1, 65535));
            len = 32'(pay_len);
            if (flaw == FLAW_LENGTH)
                len ^= 32'd1 << $urandom_range(31);
            case ($urandom_range(3))
                0:       seq = 32'd0;
                1:       seq = 32'hFFFF_FFFF;
                default: seq = $urandom;
            endcase
            push_le(64'(ver), 2);
            push_le(64'($urandom), 2);          // type, flags
            push_le(64'(len), 4);
            push_le(64'(seq), 4);
            push_le({$urandom, $urandom}, 8);   // timestamp
            for (int i = 0; i < pay_len; i++)
            begin
                case (kind)
                    PAY_NONZERO: raw_bytes.push_back(8'($urandom_range(1, 255)));
                    PAY_SPACED:  raw_bytes.push_back((i % 200 == 199) ?
                                                     8'd0 : 8'($urandom_range(1, 255)));
                    default:     raw_bytes.push_back(($urandom_range(3) == 0) ?
                                                     8'd0 : 8'($urandom));
                endcase
            end
            crc = message_crc();
            if (flaw == FLAW_CRC)
                crc ^= 32'd1 << $urandom_range(31);
            push_le(64'(crc), 4);
        end
        cobs_encode();
        if (flaw == FLAW_CUT)
            repeat ($urandom_range(1, 3))
                if (link_bytes.size() > 1)
                    void'(link_bytes.pop_back());
        if (flaw == FLAW_CODE)
            link_bytes[$urandom_range(0, link_bytes.size() - 1)] = 8'($urandom_range(1, 255));
        foreach (link_bytes[i])
            feed(link_bytes[i]);
        feed(8'd0);
        frames_sent++;
    endtask

    // Write protocol_version once every outstanding result has come back.
    task automatic set_version(input logic [15:0] v);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_version = v;
        versions_used++;
    endtask

    function automatic int pick_pct();
        case ($urandom_range(2))
            0:       return 0;
            1:       return 15;
            default: return 40;
        endcase
    endfunction

    // Well-formed messages with random content are the largest share; the rest is reads,
    // spoiled messages, noise and stray delimiters.
    task automatic run_phase(input int n_items);
        int target;
        int r;
        target = items_sent + n_items;
        while (items_sent < target)
        begin
            if (!quiet && $urandom_range(9) == 0)
            begin
                gap_pct   = pick_pct();
                stall_pct = pick_pct();
            end
            r = $urandom_range(99);
            if (r < 45)
                send_message($urandom_range(0, 8), FLAW_NONE, PAY_MIXED);
            else if (r < 62)
                send_message($urandom_range(0, 8),
                             flaw_t'($urandom_range(FLAW_VERSION, FLAW_CODE)), PAY_MIXED);
            else if (r < 80)
                read_burst($urandom_range(1, 6));
            else if (r < 92)
            begin
                repeat ($urandom_range(1, 20))
                    feed(($urandom_range(3) == 0) ? 8'd0 : 8'($urandom));
                // usually close the noise, sometimes let it run into the next message
                if ($urandom_range(3) != 0)
                    feed(8'd0);
            end
            else
                feed(8'd0);
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = 16'd0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = ACT_FEED;
        drain_check = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty frames, a short frame, a block cut by the delimiter,
        // a 0xFF code cut short, then reads of what was written.
        gap_pct   = 15;
        stall_pct = 15;
        feed(8'd0);
        feed(8'd0);
        feed(8'h03); feed(8'h11); feed(8'h22); feed(8'h02); feed(8'h33); feed(8'd0);
        feed(8'h05); feed(8'hAA); feed(8'hBB); feed(8'd0);
        feed(8'hFF); feed(8'h01); feed(8'd0);
        send_item(ACT_READ, 8'h00, 10'd0);
        send_item(ACT_READ, 8'hFF, 10'd3);
        send_item(ACT_READ, 8'h5A, 10'd1);
        send_item(ACT_READ, 8'hA5, 10'd2);
        reads_sent += 4;

        // A message needing full 0xFF blocks, then reads across what was written.
        send_message($urandom_range(254, 280), FLAW_NONE, PAY_NONZERO);
        read_burst(24);
        run_phase(PHASE_ITEMS);

        set_version(16'hFFFF);
        run_phase(PHASE_ITEMS);

        set_version(16'h0000);
        run_phase(PHASE_ITEMS);

        // last stretch runs with no gaps and no stalls
        set_version(16'($urandom));
        quiet     = 1'b1;
        gap_pct   = 0;
        stall_pct = 0;
        run_phase(PHASE_ITEMS);

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        drain_check <= 1'b1;
        repeat (2) @(posedge clk);

        $display("Sent %0d input transactions: %0d messages, %0d reads, %0d version settings.",
                 items_sent, frames_sent, reads_sent, versions_used);
        $display("Included empty, short and cut frames and a message with 0xFF block runs.");
        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
